// ===== rtl/core/complex_lms_noise_canceller_macros.svh =====
// Assertion macros used by the checker file of the LMS canceller.
`ifndef COMPLEX_LMS_NOISE_CANCELLER_MACROS_SVH
`define COMPLEX_LMS_NOISE_CANCELLER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CLMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define CLMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/clms_pkg.sv =====
// Package with types and constants of the complex LMS canceller.
package clms_pkg;

    localparam logic [15:0] STEP_RESET  = 16'd655;
    localparam logic signed [23:0] TAP_INIT_RE = 24'sd996147;
    localparam logic signed [23:0] TAP_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TAP_MIN = 24'sh800000;
    localparam logic signed [15:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SMP_MIN = 16'sh8000;
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TAP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILTER,
        ST_ERROR,
        ST_UPDATE,
        ST_OUTPUT
    } clms_state_t;

endpackage

// ===== rtl/core/clms_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
module clms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/complex_lms_noise_canceller.sv =====
// Complex LMS interference canceller: top level.
// A sample transfer keeps the input stalled through the filter, error, update and output
// states, so a new item is taken only once the last sample is through. A filter pass
// reads one tap and one window entry per cycle through one complex multiplier. The error
// state forms the error. An update pass reads each entry again and writes the adapted tap
// back. The output state then loads the output register once it is free. A tap write is
// done as the item is taken. After reset a clearing pass loads the reset window and taps
// while no item is accepted. The window is a circular buffer in RAM. The result sits in an
// output register, so the next item is taken while it waits.
module complex_lms_noise_canceller
    import clms_pkg::*;
#(
    parameter int TAP_COUNT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [15:0] primary_re,
    input  logic signed [15:0] primary_im,
    input  logic signed [15:0] reference_re,
    input  logic signed [15:0] reference_im,
    input  logic [4:0]         tap_index,
    input  logic signed [23:0] tap_re,
    input  logic signed [23:0] tap_im,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] error_re,
    output logic signed [15:0] error_im
);

    localparam int AW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST = AW'(TAP_COUNT - 1);

    clms_state_t state_reg, state_next;
    logic [15:0] step_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] head_reg, head_next;
    logic rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_k_reg, rd_k_next;
    logic signed [63:0] acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic signed [15:0] pri_re_reg, pri_im_reg, er_reg, ei_reg;
    logic out_valid_reg, out_valid_next;
    logic signed [15:0] out_re_reg, out_im_reg;

    // Memory ports.
    logic          w_we, x_we;
    logic [AW-1:0] w_waddr, x_waddr, w_raddr, x_raddr;
    logic [47:0]   w_wdata, w_rdata;
    logic [31:0]   x_wdata, x_rdata;

    clms_ram #(.WIDTH(48), .DEPTH(TAP_COUNT)) u_taps (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    clms_ram #(.WIDTH(32), .DEPTH(TAP_COUNT)) u_window (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(x_rdata)
    );

    logic signed [23:0] wr, wi;
    logic signed [15:0] xr, xi;
    assign wr = w_rdata[47:24];
    assign wi = w_rdata[23:0];
    assign xr = x_rdata[31:16];
    assign xi = x_rdata[15:0];

    // Accept conditions.
    logic in_xfer, out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Filter products, registered before accumulation.
    logic signed [39:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic p_vld_reg;
    always_ff @(posedge clk)
    begin
        p_rr_reg <= 40'(wr * xr);
        p_ii_reg <= 40'(wi * xi);
        p_ri_reg <= 40'(wr * xi);
        p_ir_reg <= 40'(wi * xr);
    end

    // Update products: e*conj(x), then times mu, then round and add.
    logic signed [33:0] g_re_reg, g_im_reg;
    logic signed [23:0] wr_d_reg, wi_d_reg;
    logic [AW-1:0] g_k_reg;
    logic g_vld_reg;
    logic signed [51:0] m_re_reg, m_im_reg;
    logic signed [23:0] wr_d2_reg, wi_d2_reg;
    logic [AW-1:0] m_k_reg;
    logic m_vld_reg;

    always_ff @(posedge clk)
    begin
        g_re_reg  <= 34'(er_reg * xr) + 34'(ei_reg * xi);
        g_im_reg  <= 34'(ei_reg * xr) - 34'(er_reg * xi);
        wr_d_reg  <= wr;
        wi_d_reg  <= wi;
        g_k_reg   <= rd_k_reg;
        m_re_reg  <= 52'(g_re_reg * $signed({1'b0, step_reg}));
        m_im_reg  <= 52'(g_im_reg * $signed({1'b0, step_reg}));
        wr_d2_reg <= wr_d_reg;
        wi_d2_reg <= wi_d_reg;
        m_k_reg   <= g_k_reg;
    end

    function automatic logic signed [23:0] upd(input logic signed [23:0] w,
                                               input logic signed [51:0] m);
        logic signed [26:0] r;
        logic signed [27:0] s;
        begin
            r = 27'((m + 52'sd33554432) >>> 26);
            s = 28'(w) + 28'(r);
            if (s > 28'(TAP_MAX))
                upd = TAP_MAX;
            else if (s < 28'(TAP_MIN))
                upd = TAP_MIN;
            else
                upd = s[23:0];
        end
    endfunction

    // Error computation from the accumulator.
    function automatic logic signed [15:0] err(input logic signed [15:0] p,
                                               input logic signed [63:0] a);
        logic signed [63:0] d;
        logic signed [63:0] r;
        begin
            d = ($signed({{48{p[15]}}, p}) <<< 20) - a;
            r = (d + 64'sd524288) >>> 20;
            if (r > 64'(SMP_MAX))
                err = SMP_MAX;
            else if (r < 64'(SMP_MIN))
                err = SMP_MIN;
            else
                err = r[15:0];
        end
    endfunction

    // Physical window address of the entry at logical position k.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        begin
            s = (CW+1)'(h) + (CW+1)'(k);
            if (s >= (CW+1)'(TAP_COUNT))
                s = s - (CW+1)'(TAP_COUNT);
            phys = s[AW-1:0];
        end
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (cnt_reg[AW-1:0] == LAST) state_next = ST_IDLE;
            ST_IDLE:   if (in_xfer && action == ACT_SAMPLE) state_next = ST_FILTER;
            ST_FILTER: if (p_vld_reg && !rd_vld_reg) state_next = ST_ERROR;
            ST_ERROR:  state_next = ST_UPDATE;
            ST_UPDATE: if (m_vld_reg && !g_vld_reg && !rd_vld_reg) state_next = ST_OUTPUT;
            ST_OUTPUT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath control and memory accesses.
    always_comb
    begin
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        rd_vld_next  = 1'b0;
        rd_k_next    = rd_k_reg;
        acc_re_next  = acc_re_reg;
        acc_im_next  = acc_im_reg;
        out_valid_next = out_valid_reg && out_stall;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0;
        x_we = 1'b0; x_waddr = '0; x_wdata = '0;
        w_raddr = '0; x_raddr = '0;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                w_we = 1'b1; x_we = 1'b1;
                w_waddr = cnt_reg[AW-1:0]; x_waddr = cnt_reg[AW-1:0];
                w_wdata = (cnt_reg == '0) ? {TAP_INIT_RE, 24'd0} : '0;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                acc_re_next = '0;
                acc_im_next = '0;
                if (in_xfer && action == ACT_TAP_WRITE && 32'(tap_index) < TAP_COUNT)
                begin
                    w_we = 1'b1;
                    w_waddr = AW'(tap_index);
                    w_wdata = {tap_re, tap_im};
                end
                else if (in_xfer && action == ACT_SAMPLE)
                begin
                    // New sample goes to the slot before the newest, over the oldest.
                    head_next = (head_reg == '0) ? LAST : head_reg - 1'b1;
                    x_we = 1'b1;
                    x_waddr = head_next;
                    x_wdata = {reference_re, reference_im};
                end
            end
            ST_FILTER, ST_UPDATE:
            begin
                if (cnt_reg < CW'(TAP_COUNT))
                begin
                    w_raddr = AW'(cnt_reg);
                    x_raddr = phys(head_reg, cnt_reg);
                    rd_vld_next = 1'b1;
                    rd_k_next = AW'(cnt_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
                if (state_reg == ST_FILTER && p_vld_reg)
                begin
                    acc_re_next = acc_re_reg + 64'(p_rr_reg) - 64'(p_ii_reg);
                    acc_im_next = acc_im_reg + 64'(p_ri_reg) + 64'(p_ir_reg);
                end
                if (state_reg == ST_UPDATE && m_vld_reg)
                begin
                    w_we = 1'b1;
                    w_waddr = m_k_reg;
                    w_wdata = {upd(wr_d2_reg, m_re_reg), upd(wi_d2_reg, m_im_reg)};
                end
            end
            ST_ERROR:
            begin
                cnt_next = '0;
            end
            ST_OUTPUT:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg <= STEP_RESET;
            cnt_reg <= '0;
            head_reg <= '0;
            rd_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                step_reg <= cfg_data;
            cnt_reg <= cnt_next;
            head_reg <= head_next;
            rd_vld_reg <= rd_vld_next;
            p_vld_reg <= rd_vld_reg && (state_reg == ST_FILTER);
            g_vld_reg <= rd_vld_reg && (state_reg == ST_UPDATE);
            m_vld_reg <= g_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_k_reg <= rd_k_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        if (in_xfer)
        begin
            pri_re_reg <= primary_re;
            pri_im_reg <= primary_im;
        end
        if (state_reg == ST_ERROR)
        begin
            er_reg <= err(pri_re_reg, acc_re_reg);
            ei_reg <= err(pri_im_reg, acc_im_reg);
        end
        if (state_reg == ST_OUTPUT && out_free)
        begin
            out_re_reg <= er_reg;
            out_im_reg <= ei_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign error_re = out_re_reg;
    assign error_im = out_im_reg;

endmodule

// ===== rtl/core/clms_checker.sv =====
// Port-level assertion checker for the LMS canceller, with its bind.
`include "complex_lms_noise_canceller_macros.svh"
module clms_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               action,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] error_re
);

    // A sample transfer blocks the input for the following cycle.
    `CLMS_ASSERT_NEXT(a_busy_after_sample, clk, rst_n, in_valid && !in_stall && !action, in_stall)
    // A result that is stalled stays valid.
    `CLMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // A stalled result keeps its value.
    `CLMS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(error_re))
    // A tap write never produces a new result in the next cycle.
    `CLMS_ASSERT_NEXT(a_tap_no_result, clk, rst_n,
        in_valid && !in_stall && action && !out_valid, !out_valid)

endmodule

bind complex_lms_noise_canceller clms_checker u_clms_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .out_valid(out_valid), .out_stall(out_stall), .error_re(error_re)
);

// ===== verif/tb.sv =====
// Self-checking testbench of the complex LMS interference canceller.
`timescale 1ns / 100ps

module tb;
    import clms_pkg::*;

    localparam int TAP_COUNT = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;
    localparam int LONG_HOLD = 1500;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic signed [15:0] primary_re;
    logic signed [15:0] primary_im;
    logic signed [15:0] reference_re;
    logic signed [15:0] reference_im;
    logic [4:0]         tap_index;
    logic signed [23:0] tap_re;
    logic signed [23:0] tap_im;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] error_re;
    logic signed [15:0] error_im;

    // One input item, with an optional hand-typed expected error.
    typedef struct {
        logic               act;
        logic signed [15:0] p_re;
        logic signed [15:0] p_im;
        logic signed [15:0] r_re;
        logic signed [15:0] r_im;
        logic [4:0]         idx;
        logic signed [23:0] t_re;
        logic signed [23:0] t_im;
        bit                 typed;
        logic signed [15:0] e_re;
        logic signed [15:0] e_im;
    } lms_item_t;

    // Model state of the canceller.
    logic signed [15:0] win_re [TAP_COUNT];
    logic signed [15:0] win_im [TAP_COUNT];
    logic signed [23:0] wt_re [TAP_COUNT];
    logic signed [23:0] wt_im [TAP_COUNT];
    logic [15:0]        mu;

    // Expected error samples, oldest first.
    logic signed [15:0] err_re_q [$];
    logic signed [15:0] err_im_q [$];

    int  mismatches = 0;
    int  samples_sent = 0;
    int  taps_written = 0;
    int  errors_checked = 0;
    int  mu_settings = 0;
    bit  hold_req = 0;
    bit  quiet = 0;

    complex_lms_noise_canceller #(.TAP_COUNT(TAP_COUNT)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .primary_re(primary_re), .primary_im(primary_im),
        .reference_re(reference_re), .reference_im(reference_im),
        .tap_index(tap_index), .tap_re(tap_re), .tap_im(tap_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .error_re(error_re), .error_im(error_im)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic longint round_down(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Reset state: empty window, only the newest-sample tap set to 0.95.
    task automatic reset_model();
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            win_re[k] = '0;
            win_im[k] = '0;
            wt_re[k] = '0;
            wt_im[k] = '0;
        end
        wt_re[0] = TAP_INIT_RE;
        mu = STEP_RESET;
    endtask

    // Filter one sample pair, adapt the taps and return the error.
    task automatic cancel_sample(input lms_item_t it, output logic signed [15:0] o_re,
                                 output logic signed [15:0] o_im);
        longint acc_re;
        longint acc_im;
        longint er;
        longint ei;
        longint gr;
        longint gi;
        acc_re = 0;
        acc_im = 0;
        for (int k = TAP_COUNT - 1; k > 0; k--)
        begin
            win_re[k] = win_re[k - 1];
            win_im[k] = win_im[k - 1];
        end
        win_re[0] = it.r_re;
        win_im[0] = it.r_im;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            acc_re += longint'(wt_re[k]) * win_re[k] - longint'(wt_im[k]) * win_im[k];
            acc_im += longint'(wt_re[k]) * win_im[k] + longint'(wt_im[k]) * win_re[k];
        end
        er = limit(round_down(longint'(it.p_re) * (longint'(1) << 20) - acc_re, 20),
                   SMP_MIN, SMP_MAX);
        ei = limit(round_down(longint'(it.p_im) * (longint'(1) << 20) - acc_im, 20),
                   SMP_MIN, SMP_MAX);
        // Update pass uses the same window and the error just formed.
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            gr = (er * win_re[k] + ei * win_im[k]) * longint'(mu);
            gi = (ei * win_re[k] - er * win_im[k]) * longint'(mu);
            wt_re[k] = 24'(limit(longint'(wt_re[k]) + round_down(gr, 26), TAP_MIN, TAP_MAX));
            wt_im[k] = 24'(limit(longint'(wt_im[k]) + round_down(gi, 26), TAP_MIN, TAP_MAX));
        end
        o_re = 16'(er);
        o_im = 16'(ei);
    endtask

    // Offer one item until the transfer happens, then update the model.
    task automatic send_item(input lms_item_t it);
        logic signed [15:0] p_re;
        logic signed [15:0] p_im;
        in_valid <= 1'b1;
        action <= it.act;
        primary_re <= it.p_re;
        primary_im <= it.p_im;
        reference_re <= it.r_re;
        reference_im <= it.r_im;
        tap_index <= it.idx;
        tap_re <= it.t_re;
        tap_im <= it.t_im;
        do
            @(posedge clk);
        while (in_stall);
        if (it.act == ACT_TAP_WRITE)
        begin
            if (it.idx < TAP_COUNT)
            begin
                wt_re[it.idx] = it.t_re;
                wt_im[it.idx] = it.t_im;
            end
            taps_written++;
        end
        else
        begin
            cancel_sample(it, p_re, p_im);
            err_re_q.push_back(it.typed ? it.e_re : p_re);
            err_im_q.push_back(it.typed ? it.e_im : p_im);
            samples_sent++;
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic sender_gap();
        int n;
        n = gap_length();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Full-scale values most of the time, small ones so the taps settle.
    function automatic logic signed [15:0] rand_sample();
        if ($urandom_range(0, 9) < 6)
            return 16'($urandom());
        return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
    endfunction

    function automatic lms_item_t rand_item();
        lms_item_t it;
        it.act = ($urandom_range(0, 9) == 0) ? ACT_TAP_WRITE : ACT_SAMPLE;
        it.p_re = rand_sample();
        it.p_im = rand_sample();
        it.r_re = rand_sample();
        it.r_im = rand_sample();
        it.idx = 5'($urandom());
        it.t_re = 24'($urandom());
        it.t_im = 24'($urandom());
        it.typed = 0;
        it.e_re = '0;
        it.e_im = '0;
        return it;
    endfunction

    // Let the block drain fully, then write the step size.
    task automatic set_step(input logic [15:0] value);
        in_valid <= 1'b0;
        while (err_re_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mu = value;
        mu_settings++;
    endtask

    task automatic run_random(input int count, input bit with_hold);
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == 20)
                hold_req = 1;
            send_item(rand_item());
            sender_gap();
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_stall <= 1'b1;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(0, 99);
                out_stall <= 1'b1;
                if (n < 80)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else if (n < 95)
                    repeat ($urandom_range(4, 15)) @(posedge clk);
                else
                    repeat ($urandom_range(30, 120)) @(posedge clk);
            end
        end
    end

    // Compare every error transfer with the oldest expectation.
    initial
    begin
        logic signed [15:0] x_re;
        logic signed [15:0] x_im;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (err_re_q.size() == 0)
                    report($sformatf("unexpected error %0d,%0d", error_re, error_im));
                else
                begin
                    x_re = err_re_q.pop_front();
                    x_im = err_im_q.pop_front();
                    errors_checked++;
                    if (error_re !== x_re)
                        report($sformatf("error_re %0d, expected %0d", error_re, x_re));
                    if (error_im !== x_im)
                        report($sformatf("error_im %0d, expected %0d", error_im, x_im));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", idle);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Main sequence: directed table, then random phases over step sizes.
    initial
    begin
        lms_item_t directed [14] = '{
            // Empty window: the error is the primary sample itself.
            '{ACT_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 5'd0, 24'sd0, 24'sd0,
              1, 16'sh7FFF, 16'sh8000},
            '{ACT_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 5'd0, 24'sd0, 24'sd0,
              1, 16'sh8000, 16'sh7FFF},
            '{ACT_SAMPLE, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 5'd0, 24'sd0, 24'sd0,
              0, 16'sd0, 16'sd0},
            // Tap writes at both ends of the index range, with extreme values.
            '{ACT_TAP_WRITE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 5'd31, 24'sh7FFFFF,
              24'sh800000, 0, 16'sd0, 16'sd0},
            '{ACT_TAP_WRITE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 5'd0, 24'sh800000,
              24'sh7FFFFF, 0, 16'sd0, 16'sd0},
            // Extreme references drive the sums into saturation.
            '{ACT_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 5'd0, 24'sd0,
              24'sd0, 0, 16'sd0, 16'sd0},
            '{ACT_SAMPLE, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 5'd0, 24'sd0,
              24'sd0, 0, 16'sd0, 16'sd0},
            '{ACT_TAP_WRITE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 5'd15, 24'sd0, 24'sd0,
              0, 16'sd0, 16'sd0},
            '{ACT_TAP_WRITE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 5'd1, 24'sd1048576,
              -24'sd1048576, 0, 16'sd0, 16'sd0},
            '{ACT_SAMPLE, 16'sd1000, -16'sd1000, 16'sd300, -16'sd200, 5'd0, 24'sd0,
              24'sd0, 0, 16'sd0, 16'sd0},
            '{ACT_SAMPLE, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 5'd0, 24'sd0, 24'sd0,
              0, 16'sd0, 16'sd0},
            '{ACT_TAP_WRITE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 5'd10, 24'sd996147,
              24'sd0, 0, 16'sd0, 16'sd0},
            '{ACT_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 5'd0, 24'sd0, 24'sd0,
              0, 16'sd0, 16'sd0},
            '{ACT_SAMPLE, 16'sd12000, 16'sd5000, 16'sd8000, -16'sd8000, 5'd0, 24'sd0,
              24'sd0, 0, 16'sd0, 16'sd0}
        };
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_SAMPLE;
        primary_re = '0;
        primary_im = '0;
        reference_re = '0;
        reference_im = '0;
        tap_index = '0;
        tap_re = '0;
        tap_im = '0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_item(directed[i]);
            sender_gap();
        end

        set_step(16'hFFFF);
        run_random(120, 1);
        set_step(16'h0000);
        run_random(80, 0);
        set_step(16'($urandom()));
        run_random(150, 0);
        set_step(STEP_RESET);
        quiet = 1;
        run_random(150, 0);
        quiet = 0;
        in_valid <= 1'b0;

        while (err_re_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sample pairs and %0d tap writes over %0d step sizes,",
                 samples_sent, taps_written, mu_settings + 1);
        $display("with %0d error samples checked and %0d mismatches.",
                 errors_checked, mismatches);
        if (mismatches == 0 && err_re_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
